FILE: hw/rtl/ssa_pkg.sv
// Shared types and constants of the swap slot allocator.
// Holds the beat payload structs, operation and status codes, and the
// command and status groups between the controller and the datapath.
package ssa_pkg;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ID_W    = 32;
  localparam int unsigned FRAME_W = 20;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned CFG_W   = 11;

  localparam logic [CFG_W-1:0] SLOTS_RESET = 11'd1024;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_STORE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RETRIEVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL       = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [STAT_W-1:0] ST_ZERO_FRAME = 3'd3;
  localparam logic [STAT_W-1:0] ST_DUPLICATE  = 3'd4;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ID_W-1:0]    swap_id;
    logic [FRAME_W-1:0] frame_number;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SLOT_W-1:0] slot;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clear_step;
    logic capture;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

FILE: hw/rtl/ssa_ctrl.sv
// Sequencing state machine of the swap slot allocator.
// Depends on ssa_pkg for the command and status structs and operation codes.
module ssa_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [ssa_pkg::KIND_W-1:0]   in_kind_i,
  output logic                         in_ready_o,
  input  ssa_pkg::dp_status_t          status_i,
  output ssa_pkg::dp_cmd_t             cmd_o
);
  import ssa_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_SCAN   = 4'b0100,
    S_COMMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          // the unused operation code needs no walk
          if (in_kind_i inside {KIND_STORE, KIND_RETRIEVE, KIND_DELETE}) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_COMMIT;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // hold until the result register can take the beat
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/ssa_datapath.sv
// Slot table, walk counter, search trackers and result register.
// Depends on ssa_pkg for payload structs, codes and control structs.
module ssa_datapath #(
  parameter int unsigned NUM_SLOTS = 1024,
  parameter int unsigned ID_WIDTH  = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ssa_pkg::dp_cmd_t            cmd_i,
  output ssa_pkg::dp_status_t         status_o,
  input  ssa_pkg::in_item_t           in_item_i,
  input  logic [ssa_pkg::CFG_W-1:0]   slots_in_use_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ssa_pkg::out_item_t          out_item_o
);
  import ssa_pkg::*;

  localparam int unsigned AW    = $clog2(NUM_SLOTS);
  localparam int unsigned CW    = (AW > CFG_W) ? AW : CFG_W;
  localparam int unsigned WORDW = ID_WIDTH + 2;
  localparam int unsigned USED  = ID_WIDTH + 1;
  localparam int unsigned BOUND = ID_WIDTH;
  localparam logic [AW:0]   CNT_END  = (AW + 1)'(NUM_SLOTS);
  localparam logic [AW:0]   CNT_LAST = (AW + 1)'(NUM_SLOTS - 1);
  localparam logic [AW-1:0] IDX_LAST = AW'(NUM_SLOTS - 1);

  // each word: used bit, bound bit, bound id
  logic [WORDW-1:0] mem_q [NUM_SLOTS];
  logic [WORDW-1:0] rd_q;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [WORDW-1:0] wr_data;

  logic [AW:0]    cnt_q, cnt_d;
  logic           issue;
  logic           eval_vld_q;
  logic [AW-1:0]  eval_idx_q;

  logic [KIND_W-1:0]   req_kind_q;
  logic [ID_WIDTH-1:0] req_id_q;
  logic                req_frame_zero_q;

  logic          free_found_q, free_found_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic          match_found_q, match_found_d;
  logic [AW-1:0] match_idx_q, match_idx_d;

  logic      out_valid_q;
  out_item_t out_item_q, result;
  logic [AW-1:0] res_idx;
  logic [SLOT_W+AW-1:0] res_idx_wide;
  logic      in_range;

  assign issue = cmd_i.scan_step && (cnt_q != CNT_END);
  assign in_range = CW'(eval_idx_q) < CW'(slots_in_use_i);

  // walk counter, shared by the clearing pass and the search
  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.clear_step) begin
      cnt_d = (cnt_q == CNT_LAST) ? '0 : cnt_q + 1'b1;
    end else if (issue) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd_i.commit || cmd_i.capture) begin
      cnt_d = '0;
    end
  end

  // search trackers: lowest free slot in range, lowest matching binding
  always_comb begin
    free_found_d  = free_found_q;
    free_idx_d    = free_idx_q;
    match_found_d = match_found_q;
    match_idx_d   = match_idx_q;
    if (cmd_i.capture) begin
      free_found_d  = 1'b0;
      match_found_d = 1'b0;
    end else if (eval_vld_q) begin
      if (!free_found_q && !rd_q[USED] && in_range) begin
        free_found_d = 1'b1;
        free_idx_d   = eval_idx_q;
      end
      if (!match_found_q && rd_q[BOUND] && (rd_q[ID_WIDTH-1:0] == req_id_q)) begin
        match_found_d = 1'b1;
        match_idx_d   = eval_idx_q;
      end
    end
  end

  // result and table update for the current request
  always_comb begin
    result.status = ST_OK;
    res_idx       = '0;
    wr_en         = 1'b0;
    wr_addr       = cnt_q[AW-1:0];
    wr_data       = '0;
    case (req_kind_q)
      KIND_STORE: begin
        if (!free_found_q) begin
          result.status = ST_FULL;
        end else begin
          res_idx = free_idx_q;
          wr_en   = 1'b1;
          wr_addr = free_idx_q;
          // a duplicate still consumes the slot but binds nothing
          wr_data = {1'b1, !match_found_q, req_id_q};
          if (match_found_q) begin
            result.status = ST_DUPLICATE;
          end
        end
      end
      KIND_RETRIEVE, KIND_DELETE: begin
        if (!match_found_q) begin
          result.status = ST_NOT_FOUND;
        end else if ((req_kind_q == KIND_RETRIEVE) && req_frame_zero_q) begin
          result.status = ST_ZERO_FRAME;
        end else begin
          res_idx = match_idx_q;
          wr_en   = 1'b1;
          wr_addr = match_idx_q;
          wr_data = {2'b00, req_id_q};
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
    res_idx_wide = {{SLOT_W{1'b0}}, res_idx};
    result.slot  = res_idx_wide[SLOT_W-1:0];
    if (cmd_i.clear_step) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[AW-1:0];
      wr_data = '0;
    end else if (!cmd_i.commit) begin
      wr_en = 1'b0;
    end
  end

  // slot table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[cnt_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      eval_vld_q    <= 1'b0;
      free_found_q  <= 1'b0;
      match_found_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      cnt_q         <= cnt_d;
      eval_vld_q    <= issue;
      free_found_q  <= free_found_d;
      match_found_q <= match_found_d;
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    eval_idx_q  <= cnt_q[AW-1:0];
    free_idx_q  <= free_idx_d;
    match_idx_q <= match_idx_d;
    if (cmd_i.capture) begin
      req_kind_q       <= in_item_i.kind;
      req_id_q         <= in_item_i.swap_id[ID_WIDTH-1:0];
      req_frame_zero_q <= (in_item_i.frame_number == '0);
    end
    if (cmd_i.commit) begin
      out_item_q <= result;
    end
  end

  assign status_o.clear_last = (cnt_q == CNT_LAST);
  assign status_o.scan_done  = eval_vld_q && (eval_idx_q == IDX_LAST);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: hw/rtl/swap_slot_allocator_core.sv
// Swap slot allocator: each input beat gets one result beat after a walk over
// the slot table, one entry per cycle on its read port (no walk for the unused
// operation code); a new request is taken only once the last one has committed.
// After reset a clearing pass writes zero to every table entry; input is held off
// until it ends, configuration writes are taken at once.
// Depends on ssa_pkg, ssa_ctrl and ssa_datapath.
module swap_slot_allocator_core #(
  parameter int unsigned NUM_SLOTS = 1024,
  parameter int unsigned ID_WIDTH  = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ssa_pkg::in_item_t  in_item_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ssa_pkg::out_item_t out_item_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ssa_pkg::*;

  logic [CFG_W-1:0] slots_in_use_q;
  logic             cfg_sel;
  dp_cmd_t          cmd;
  dp_status_t       status;

  // Register 0 (slots_in_use) sits at byte address 0; address 4 reads zero
  // and drops writes. The port never stalls.
  assign pready  = 1'b1;
  assign cfg_sel = !paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= SLOTS_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      slots_in_use_q <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = cfg_sel ? {{(32 - CFG_W){1'b0}}, slots_in_use_q} : '0;

  // The controller sequences clear, accept, walk and commit; the datapath
  // holds the table, the trackers of the walk and the result register, so
  // a finished result waits there while the next request is taken.
  ssa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_item_i.kind),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // A count above NUM_SLOTS acts as NUM_SLOTS and zero gives no slot at all;
  // both fall out of the range compare made on every walked entry.
  ssa_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .ID_WIDTH  (ID_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .in_item_i      (in_item_i),
    .slots_in_use_i (slots_in_use_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o)
  );

endmodule

FILE: verif/swap_slot_allocator_core_tb.sv
// Self-checking testbench of swap_slot_allocator_core: a stimulus table, then random
// store, retrieve, delete and unused-code traffic checked by a first-fit slot predictor.
// Depends on ssa_pkg and on the swap_slot_allocator_core RTL.
module swap_slot_allocator_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssa_pkg::*;

  localparam int unsigned NUM_SLOTS = 1024;
  localparam int unsigned ID_WIDTH  = 32;
  localparam logic [31:0] ID_MASK   = (ID_WIDTH >= 32) ? 32'hFFFF_FFFF
                                                       : ((32'd1 << ID_WIDTH) - 32'd1);

  // operation code the block leaves undefined: it answers ok with slot 0
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // byte address of the slot count register
  localparam logic [2:0] REG_SLOTS_ADDR = 3'd0;

  localparam int unsigned POOL_SIZE      = 48;
  localparam int unsigned PRESSURE_AT    = 60;
  localparam int unsigned PRESSURE_HOLD  = 3000;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  localparam logic [31:0]        ID_LO     = 32'h0000_0000;
  localparam logic [31:0]        ID_HI     = 32'hFFFF_FFFF;
  localparam logic [31:0]        ID_MID    = 32'h1234_5678;
  localparam logic [FRAME_W-1:0] FRAME_MAX = 20'hF_FFFF;

  typedef struct packed {
    bit               is_cfg;
    logic [CFG_W-1:0] cfg_val;
    in_item_t         beat;
    bit               typed;
    out_item_t        want;
  } dir_row_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and the signals of the block
  // ---------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      req_valid = 1'b0;
  logic      req_ready;
  in_item_t  req_beat  = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  out_item_t rsp_beat;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  swap_slot_allocator_core #(
    .NUM_SLOTS (NUM_SLOTS),
    .ID_WIDTH  (ID_WIDTH)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_item_i   (req_beat),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_item_o  (rsp_beat),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // Slot predictor: own copy of the used bitmap, the bindings and the slot count
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] slot_limit_q = SLOTS_RESET;
  bit               used_q   [NUM_SLOTS];
  bit               bound_q  [NUM_SLOTS];
  logic [31:0]      bound_id_q [NUM_SLOTS];

  out_item_t  expected_q [$];
  dir_row_t   directed_tbl [$];
  logic [31:0] id_pool [POOL_SIZE];
  int unsigned fail_count = 0;
  bit          req_burst = 1'b0;
  bit          rsp_burst = 1'b0;
  out_item_t   rsp_want;

  // Lowest slot bound to id, or -1. Only valid bindings are compared, so an
  // entry that was never written plays no part.
  function automatic int bound_slot_of(input logic [31:0] id);
    int s;
    for (s = 0; s < NUM_SLOTS; s++)
      if (bound_q[s] && bound_id_q[s] == id) return s;
    return -1;
  endfunction

  // Advance the predicted state by one request and return its result.
  function automatic out_item_t predict_slot_op(input in_item_t it);
    out_item_t   r;
    logic [31:0] id;
    int          hit;
    int          lim;
    int          s;
    r.status = ST_OK;
    r.slot   = '0;
    id  = it.swap_id & ID_MASK;
    hit = bound_slot_of(id);
    case (it.kind)
      KIND_STORE: begin
        // a count above the table size acts as the table size; 0 means none
        lim = (slot_limit_q > NUM_SLOTS) ? NUM_SLOTS : int'(slot_limit_q);
        s = 0;
        while (s < lim && used_q[s]) s++;
        if (s >= lim) begin
          r.status = ST_FULL;
        end else begin
          // the slot is consumed even when the id turns out to be bound already
          used_q[s] = 1'b1;
          r.slot    = s[SLOT_W-1:0];
          if (hit >= 0) begin
            r.status = ST_DUPLICATE;
          end else begin
            bound_id_q[s] = id;
            bound_q[s]    = 1'b1;
          end
        end
      end
      KIND_RETRIEVE, KIND_DELETE: begin
        // lookup covers the whole table, whatever the slot count is
        if (hit < 0) begin
          r.status = ST_NOT_FOUND;
        end else if (it.kind == KIND_RETRIEVE && it.frame_number == '0) begin
          r.status = ST_ZERO_FRAME;
        end else begin
          used_q[hit]  = 1'b0;
          bound_q[hit] = 1'b0;
          r.slot       = hit[SLOT_W-1:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void log_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void dir_op(input logic [KIND_W-1:0] kind, input logic [31:0] id,
                                 input logic [FRAME_W-1:0] frame, input bit typed,
                                 input logic [STAT_W-1:0] st, input logic [SLOT_W-1:0] slot);
    dir_row_t row;
    row                    = '0;
    row.beat.kind          = kind;
    row.beat.swap_id       = id;
    row.beat.frame_number  = frame;
    row.typed              = typed;
    row.want.status        = st;
    row.want.slot          = slot;
    directed_tbl.push_back(row);
  endfunction

  function automatic void dir_cfg(input logic [CFG_W-1:0] val);
    dir_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_val = val;
    directed_tbl.push_back(row);
  endfunction

  // Draw a request. pool_n of 0 selects fill traffic: mostly stores of fresh
  // ids, with stray lookups of ids that are never bound. Otherwise ids come
  // mostly from the pool, stores preferring unbound ids and lookups bound ones,
  // so that sequences get past the not-found answer.
  function automatic in_item_t random_op(input int pool_n);
    in_item_t it;
    int       r;
    int       tries;
    bit       want_bound;
    r               = $urandom_range(99);
    it.swap_id      = $urandom;
    it.frame_number = FRAME_W'($urandom);
    if ($urandom_range(11) == 0) it.frame_number = '0;
    else if ($urandom_range(11) == 0) it.frame_number = FRAME_MAX;
    if (pool_n == 0) begin
      it.kind = (r < 94) ? KIND_STORE : (r < 97) ? KIND_RETRIEVE : KIND_DELETE;
    end else begin
      if (r < 44)      it.kind = KIND_STORE;
      else if (r < 68) it.kind = KIND_RETRIEVE;
      else if (r < 95) it.kind = KIND_DELETE;
      else             it.kind = KIND_UNUSED;
      if ($urandom_range(9) != 0) begin
        want_bound = (it.kind != KIND_STORE);
        tries      = 0;
        do begin
          it.swap_id = id_pool[$urandom_range(pool_n - 1)];
          tries++;
        end while (tries < 8 && ((bound_slot_of(it.swap_id & ID_MASK) >= 0) != want_bound));
      end
    end
    return it;
  endfunction

  // Offer one request beat after a random gap and hold it until accepted.
  // Valid is only lowered when a gap follows, so it never drops and rises in
  // the same step.
  task automatic offer_request(input in_item_t it, input bit typed, input out_item_t want);
    int        gap;
    out_item_t pred;
    if ($urandom_range(31) == 0) req_burst = !req_burst;
    gap = req_burst ? 0 : $urandom_range(13);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_beat  <= it;
    @(posedge clk);
    while (!(req_valid && req_ready)) @(posedge clk);
    // the predictor always runs; typed rows replace its answer by the table's
    pred = predict_slot_op(it);
    expected_q.push_back(typed ? want : pred);
  endtask

  // Drop valid and wait until every expected result beat has come back.
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input bit wr, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write the slot count, read it back, and follow it in the predictor.
  task automatic program_slot_count(input logic [CFG_W-1:0] val);
    logic [31:0] rd;
    apb_access(1'b1, REG_SLOTS_ADDR, {{(32-CFG_W){1'b0}}, val}, rd);
    slot_limit_q = val;
    apb_access(1'b0, REG_SLOTS_ADDR, '0, rd);
    if (rd != {{(32-CFG_W){1'b0}}, val})
      log_failure($sformatf("slot count readback exp %0d got %0d", val, rd));
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] cfg, input int n, input int pool_n);
    wait_for_drain();
    program_slot_count(cfg);
    repeat (n) offer_request(random_op(pool_n), 1'b0, '0);
    wait_for_drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result beat with the oldest
  // expectation, field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) begin
      if (expected_q.size() == 0) begin
        log_failure($sformatf("unexpected result status %0d slot %0d",
                              rsp_beat.status, rsp_beat.slot));
      end else begin
        rsp_want = expected_q.pop_front();
        if (rsp_beat.status != rsp_want.status || rsp_beat.slot != rsp_want.slot)
          log_failure($sformatf("status exp %0d got %0d, slot exp %0d got %0d",
                                rsp_want.status, rsp_beat.status,
                                rsp_want.slot, rsp_beat.slot));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: stall at random once a result is on offer, with stretches
  // of no stalls, and hold off once for a long stretch so that the block
  // fills up and pushes back on its request side
  // ---------------------------------------------------------------------------
  initial begin : rsp_sink
    int hold;
    int seen;
    seen = 0;
    forever begin
      if ($urandom_range(31) == 0) rsp_burst = !rsp_burst;
      hold = rsp_burst ? 0 : $urandom_range(13);
      if (seen == PRESSURE_AT) begin
        rsp_ready <= 1'b0;
        repeat (PRESSURE_HOLD) @(posedge clk);
        rsp_ready <= 1'b1;
      end else if (hold == 0) begin
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b0;
        @(posedge clk);
        while (!rsp_valid) @(posedge clk);
        repeat (hold - 1) @(posedge clk);
        rsp_ready <= 1'b1;
      end
      @(posedge clk);
      while (!(rsp_valid && rsp_ready)) @(posedge clk);
      seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no beat of any kind moves for too long
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("** swap_slot_allocator_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [31:0] rd;
    int          free_slots;
    int          i;

    // the pool holds both id extremes and random ids
    for (i = 0; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    id_pool[0] = ID_LO;
    id_pool[1] = ID_HI;

    // Directed table at the reset slot count. Slot 2 is consumed by the
    // duplicate store and stays used for the rest of the run.
    dir_op(KIND_RETRIEVE, ID_LO,  20'd1,     1'b1, ST_NOT_FOUND,  10'd0);
    dir_op(KIND_DELETE,   ID_HI,  20'd0,     1'b1, ST_NOT_FOUND,  10'd0);
    dir_op(KIND_STORE,    ID_LO,  20'd0,     1'b1, ST_OK,         10'd0);
    dir_op(KIND_STORE,    ID_HI,  FRAME_MAX, 1'b1, ST_OK,         10'd1);
    dir_op(KIND_STORE,    ID_LO,  FRAME_MAX, 1'b1, ST_DUPLICATE,  10'd2);
    dir_op(KIND_RETRIEVE, ID_LO,  20'd0,     1'b1, ST_ZERO_FRAME, 10'd0);
    dir_op(KIND_RETRIEVE, ID_LO,  FRAME_MAX, 1'b1, ST_OK,         10'd0);
    dir_op(KIND_STORE,    ID_MID, 20'd1,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_UNUSED,   ID_HI,  FRAME_MAX, 1'b1, ST_OK,         10'd0);
    dir_op(KIND_DELETE,   ID_HI,  20'd0,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_DELETE,   ID_HI,  20'd0,     1'b1, ST_NOT_FOUND,  10'd0);
    dir_op(KIND_STORE,    ID_HI,  20'd5,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_STORE,    ID_LO,  20'd5,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_RETRIEVE, ID_MID, 20'd1,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_DELETE,   ID_LO,  20'd0,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_DELETE,   ID_HI,  20'd0,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_STORE,    ID_MID, 20'd3,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_STORE,    ID_LO,  20'd3,     1'b0, ST_OK,         10'd0);
    // one slot only: slot 0 is taken, so the next store finds the table full
    dir_cfg(11'd1);
    dir_op(KIND_STORE,    ID_HI,  20'd9,     1'b1, ST_FULL,       10'd0);
    dir_op(KIND_RETRIEVE, ID_MID, 20'd7,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_STORE,    ID_HI,  20'd9,     1'b0, ST_OK,         10'd0);
    // no slots at all; bindings above the count can still be freed
    dir_cfg(11'd0);
    dir_op(KIND_STORE,    ID_MID, 20'd2,     1'b1, ST_FULL,       10'd0);
    dir_op(KIND_DELETE,   ID_LO,  20'd0,     1'b0, ST_OK,         10'd0);
    dir_op(KIND_RETRIEVE, ID_HI,  FRAME_MAX, 1'b0, ST_OK,         10'd0);
    // count above the table size acts as the table size
    dir_cfg(11'd2047);
    dir_op(KIND_STORE,    ID_HI,  FRAME_MAX, 1'b0, ST_OK,         10'd0);
    dir_op(KIND_DELETE,   ID_HI,  FRAME_MAX, 1'b0, ST_OK,         10'd0);

    // hold reset at the start, then release it for good
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // the register reads its reset value while the clearing pass runs
    apb_access(1'b0, REG_SLOTS_ADDR, '0, rd);
    if (rd != {{(32-CFG_W){1'b0}}, SLOTS_RESET})
      log_failure($sformatf("slot count after reset exp %0d got %0d", SLOTS_RESET, rd));

    foreach (directed_tbl[i]) begin
      if (directed_tbl[i].is_cfg) begin
        wait_for_drain();
        program_slot_count(directed_tbl[i].cfg_val);
      end else begin
        offer_request(directed_tbl[i].beat, directed_tbl[i].typed, directed_tbl[i].want);
      end
    end
    wait_for_drain();

    // random phases over several slot counts, the extremes among them
    run_phase(11'd8,    120, 12);
    run_phase(11'd1,     50, 12);
    run_phase(11'd0,     25, 12);
    run_phase(11'd2047, 120, POOL_SIZE);
    run_phase(11'd3,     50, 6);

    // fill the whole table so that the top slot and the full answer show up
    wait_for_drain();
    free_slots = 0;
    for (i = 0; i < NUM_SLOTS; i++)
      if (!used_q[i]) free_slots++;
    run_phase(11'd1024, free_slots + free_slots / 12 + 8, 0);
    run_phase(11'd1024, 30, POOL_SIZE);

    // let a full walk pass so that any stray result beat is caught
    repeat (NUM_SLOTS + 8) @(posedge clk);
    if (expected_q.size() != 0)
      log_failure($sformatf("%0d results never arrived", expected_q.size()));

    if (fail_count == 0) begin
      $display("** swap_slot_allocator_core: PASSED **");
    end else begin
      $display("** swap_slot_allocator_core: FAILED **");
    end
    $finish;
  end

endmodule
